// ===== rtl/text_console_writer_assert.svh =====
// Assertion macros for the console writer checker; clock clk, reset rst_n.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [7:0] CH_NUL = 8'd0;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_FF  = 8'd12;
    localparam logic [7:0] CH_CR  = 8'd13;

    localparam logic [7:0]  SPACE_CHAR   = 8'h20;
    localparam logic [7:0]  ATTR_RESET   = 8'h07;
    localparam logic [15:0] SCROLL_BLANK = 16'h0720;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] char_code;
        logic [7:0] column_in;
        logic [7:0] row_in;
    } req_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
    } rsp_t;

    typedef struct packed {
        logic        start;
        logic [7:0]  dividend;
        logic [7:0]  divisor;
        logic [15:0] recip;
    } mod_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] remainder;
    } mod_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/tcw_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tcw_chan_if #(
    parameter type data_t = logic
) ();
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tcw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

// ===== rtl/tcw_mod_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  tcw_pkg::mod_req_t mreq,
    output tcw_pkg::mod_rsp_t mrsp
);
    import tcw_pkg::*;

    logic [7:0]  num_reg;
    logic [7:0]  div_reg;
    logic [7:0]  quo_reg;
    logic [7:0]  rem_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [23:0] scaled;
    logic [15:0] product;

    // quotient by reciprocal multiplication, exact for 8-bit operands
    assign scaled  = 24'(mreq.dividend) * 24'(mreq.recip);
    assign product = 16'(quo_reg) * 16'(div_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= mreq.start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mreq.start)
        begin
            num_reg <= mreq.dividend;
            div_reg <= mreq.divisor;
            quo_reg <= scaled[23:16];
        end
        if (busy_reg)
        begin
            rem_reg <= num_reg - product[7:0];
        end
    end

    assign mrsp.done      = done_reg;
    assign mrsp.remainder = rem_reg;
endmodule

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// Character write with no scroll, carriage return, line feed off the bottom row, byte zero: S_EXEC,
// S_DONE. Set cursor and read cell: two runs of the shared remainder unit (S_MCOL, S_MROW); a read
// adds S_READ, S_RDATA. Clear and form feed fill every cell; a scroll copies rows up in S_SCROLL,
// then blanks the bottom row; one cell per RAM write; a tab writes up to TAB_WIDTH blank cells. One
// item at a time, taken while a result waits. Reset: cursor 0,0, attribute 0x07, then an S_FILL pass
// writes 0x0720 to every cell; no item is taken during that pass.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    tcw_chan_if.sink   cfg,
    tcw_chan_if.sink   req,
    tcw_chan_if.source rsp
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int PW    = CW + 1;
    localparam int CLW   = $clog2(COLUMNS);
    localparam int RLW   = $clog2(ROWS);

    localparam logic [15:0] RECIP_COLS = 16'((65536 + COLUMNS - 1) / COLUMNS);
    localparam logic [15:0] RECIP_ROWS = 16'((65536 + ROWS - 1) / ROWS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_FILL   = 4'd2;
    localparam logic [3:0] S_SCROLL = 4'd3;
    localparam logic [3:0] S_TAB    = 4'd4;
    localparam logic [3:0] S_MCOL   = 4'd5;
    localparam logic [3:0] S_MROW   = 4'd6;
    localparam logic [3:0] S_READ   = 4'd7;
    localparam logic [3:0] S_RDATA  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]     state_reg, state_next;
    logic [3:0]     ret_reg, ret_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CLW-1:0] col_reg, col_next;
    logic [RLW-1:0] row_reg, row_next;
    logic [CLW-1:0] mcol_reg, mcol_next;
    logic [RLW-1:0] mrow_reg, mrow_next;
    logic [7:0]     attr_reg, attr_next;
    logic [15:0]    fill_reg, fill_next;
    req_t           item_reg, item_next;
    logic [15:0]    cell_reg, cell_next;
    logic           out_valid_reg, out_valid_next;
    rsp_t           out_reg, out_next;

    mod_req_t       mod_req;
    mod_rsp_t       mod_rsp;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [15:0]    ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [15:0]    ram_rdata;

    logic [CLW-1:0] addr_col;
    logic [RLW-1:0] addr_row;
    logic [PW-1:0]  pos;
    logic [PW-1:0]  tab_addr;
    logic [CW-1:0]  scroll_src;
    logic [CW-1:0]  scroll_dst;
    logic [CLW:0]   tab_sum;
    logic           tab_wrap;
    logic           at_bottom;
    logic           at_right;
    logic           is_glyph;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcw_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .mreq  (mod_req),
        .mrsp  (mod_rsp)
    );

    assign addr_col   = (state_reg == S_READ) ? mcol_reg : col_reg;
    assign addr_row   = (state_reg == S_READ) ? mrow_reg : row_reg;
    assign pos        = PW'(addr_row) * PW'(COLUMNS) + PW'(addr_col);
    assign tab_addr   = pos + PW'(cnt_reg);
    assign scroll_src = cnt_reg + CW'(COLUMNS);
    assign scroll_dst = cnt_reg - 1'b1;
    assign tab_sum    = (CLW + 1)'(col_reg) + (CLW + 1)'(TAB_WIDTH);
    assign tab_wrap   = tab_sum >= (CLW + 1)'(COLUMNS);
    assign at_bottom  = row_reg == RLW'(ROWS - 1);
    assign at_right   = col_reg == CLW'(COLUMNS - 1);
    assign is_glyph   = (item_reg.char_code != CH_NUL) && (item_reg.char_code != CH_TAB)
                        && (item_reg.char_code != CH_LF) && (item_reg.char_code != CH_FF)
                        && (item_reg.char_code != CH_CR);

    assign mod_req.start = ((state_reg == S_EXEC)
                            && ((item_reg.command == CMD_SET) || (item_reg.command == CMD_READ)))
                           || ((state_reg == S_MCOL) && mod_rsp.done);
    assign mod_req.dividend = (state_reg == S_MCOL) ? item_reg.row_in : item_reg.column_in;
    assign mod_req.divisor  = (state_reg == S_MCOL) ? 8'(ROWS) : 8'(COLUMNS);
    assign mod_req.recip    = (state_reg == S_MCOL) ? RECIP_ROWS : RECIP_COLS;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos[AW-1:0];
        ram_wdata = {attr_reg, item_reg.char_code};
        ram_raddr = pos[AW-1:0];
        unique case (state_reg)
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = fill_reg;
            end
            S_SCROLL:
            begin
                ram_we    = (cnt_reg != '0);
                ram_waddr = scroll_dst[AW-1:0];
                ram_wdata = ram_rdata;
                ram_raddr = scroll_src[AW-1:0];
            end
            S_TAB:
            begin
                ram_we    = tab_addr < PW'(CELLS);
                ram_waddr = tab_addr[AW-1:0];
                ram_wdata = {attr_reg, SPACE_CHAR};
            end
            S_EXEC:
            begin
                ram_we = (item_reg.command == CMD_WRITE) && is_glyph;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        mcol_next      = mcol_reg;
        mrow_next      = mrow_reg;
        attr_next      = attr_reg;
        fill_next      = fill_reg;
        item_next      = item_reg;
        cell_next      = cell_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (cfg.valid)
        begin
            attr_next = cfg.data;
        end
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    item_next  = req.data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cell_next  = '0;
                state_next = S_DONE;
                unique case (item_reg.command) inside
                    CMD_WRITE:
                    begin
                        unique case (item_reg.char_code)
                            CH_NUL:
                            begin
                            end
                            CH_CR:
                            begin
                                col_next = '0;
                            end
                            CH_LF:
                            begin
                                if (at_bottom)
                                begin
                                    cnt_next   = '0;
                                    ret_next   = S_DONE;
                                    state_next = S_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            CH_FF:
                            begin
                                fill_next  = {attr_reg, SPACE_CHAR};
                                cnt_next   = '0;
                                ret_next   = S_DONE;
                                state_next = S_FILL;
                                col_next   = '0;
                                row_next   = '0;
                            end
                            CH_TAB:
                            begin
                                cnt_next   = '0;
                                state_next = S_TAB;
                                if (at_bottom && tab_wrap)
                                begin
                                    row_next   = RLW'(ROWS - 2);
                                    ret_next   = S_TAB;
                                    state_next = S_SCROLL;
                                end
                            end
                            default:
                            begin
                                if (at_right)
                                begin
                                    col_next = '0;
                                    if (at_bottom)
                                    begin
                                        cnt_next   = '0;
                                        ret_next   = S_DONE;
                                        state_next = S_SCROLL;
                                    end
                                    else
                                    begin
                                        row_next = row_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                        endcase
                    end
                    CMD_SET, CMD_READ:
                    begin
                        state_next = S_MCOL;
                    end
                    CMD_CLEAR:
                    begin
                        fill_next  = {attr_reg, SPACE_CHAR};
                        cnt_next   = '0;
                        ret_next   = S_DONE;
                        state_next = S_FILL;
                    end
                endcase
            end
            S_FILL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ret_reg;
                end
            end
            S_SCROLL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(CELLS - COLUMNS))
                begin
                    cnt_next   = cnt_reg;
                    fill_next  = SCROLL_BLANK;
                    state_next = S_FILL;
                end
            end
            S_TAB:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(TAB_WIDTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                    if (tab_wrap)
                    begin
                        col_next = CLW'(tab_sum - (CLW + 1)'(COLUMNS));
                        if (!at_bottom)
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = tab_sum[CLW-1:0];
                    end
                end
            end
            S_MCOL:
            begin
                if (mod_rsp.done)
                begin
                    mcol_next  = mod_rsp.remainder[CLW-1:0];
                    state_next = S_MROW;
                end
            end
            S_MROW:
            begin
                if (mod_rsp.done)
                begin
                    mrow_next = mod_rsp.remainder[RLW-1:0];
                    if (item_reg.command == CMD_SET)
                    begin
                        col_next   = mcol_reg;
                        row_next   = mod_rsp.remainder[RLW-1:0];
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                cell_next  = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next      = 1'b1;
                    out_next.cell_value = cell_reg;
                    out_next.cursor_col = 7'(col_reg);
                    out_next.cursor_row = 5'(row_reg);
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            ret_reg       <= S_IDLE;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            fill_reg      <= SCROLL_BLANK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            attr_reg      <= attr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcol_reg <= mcol_next;
        mrow_reg <= mrow_next;
        item_reg <= item_next;
        cell_reg <= cell_next;
        out_reg  <= out_next;
    end
endmodule

`default_nettype wire

// ===== rtl/tcw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_writer_assert.svh"

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [6:0] cursor_col,
    input wire logic [4:0] cursor_row
);
    `TCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
    `TCW_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "accepted while busy")
    `TCW_ASSERT_NOW(a_cursor_range, rsp_valid, (cursor_col < COLUMNS) && (cursor_row < ROWS), "cursor out of range")
endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .cursor_col (rsp.data.cursor_col),
    .cursor_row (rsp.data.cursor_row)
);

`default_nettype wire

// ===== sim/text_console_writer_tb.sv =====
`timescale 1ns / 1ps

module text_console_writer_tb;

    import tcw_pkg::*;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int TAB_WIDTH    = 8;
    localparam int CELL_COUNT   = COLUMNS * ROWS;
    localparam int DRAIN_CYCLES = CELL_COUNT + TAB_WIDTH + 64;
    localparam int STALL_LIMIT  = 10 * (CELL_COUNT + TAB_WIDTH + 600);
    localparam int PHASE_ITEMS  = 200;

    logic clk;
    logic rst_n;

    tcw_chan_if #(.data_t(logic [7:0])) cfg_if ();
    tcw_chan_if #(.data_t(req_t))       req_if ();
    tcw_chan_if #(.data_t(rsp_t))       rsp_if ();

    text_console_writer #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic [15:0] screen_model [CELL_COUNT];
    int          model_col;
    int          model_row;
    logic [7:0]  attr_model;

    rsp_t console_replies [$];
    int   errors;
    int   items_sent;
    int   burst_left;
    bit   req_raised;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void fill_screen(input logic [15:0] value);
        for (int i = 0; i < CELL_COUNT; i++)
            screen_model[i] = value;
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i + COLUMNS < CELL_COUNT; i++)
            screen_model[i] = screen_model[i + COLUMNS];
        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            screen_model[i] = SCROLL_BLANK;
    endfunction

    function automatic void put_char(input logic [7:0] ch);
        int          pos;
        logic [15:0] blank;
        blank = {attr_model, SPACE_CHAR};
        case (ch)
            CH_NUL: ;
            CH_CR: model_col = 0;
            CH_LF:
            begin
                if (model_row == ROWS - 1)
                    scroll_screen();
                else
                    model_row++;
            end
            CH_FF:
            begin
                fill_screen(blank);
                model_col = 0;
                model_row = 0;
            end
            CH_TAB:
            begin
                if (model_row == ROWS - 1 && model_col + TAB_WIDTH >= COLUMNS)
                begin
                    scroll_screen();
                    model_row = ROWS - 2;
                end
                pos = model_row * COLUMNS + model_col;
                for (int k = 0; k < TAB_WIDTH; k++)
                    if (pos + k < CELL_COUNT)
                        screen_model[pos + k] = blank;
                if (model_col + TAB_WIDTH >= COLUMNS)
                begin
                    model_col = (model_col + TAB_WIDTH) % COLUMNS;
                    model_row++;
                end
                else
                begin
                    model_col += TAB_WIDTH;
                end
            end
            default:
            begin
                pos = model_row * COLUMNS + model_col;
                if (pos < CELL_COUNT)
                    screen_model[pos] = {attr_model, ch};
                model_col++;
                if (model_col >= COLUMNS)
                begin
                    model_col = 0;
                    if (model_row == ROWS - 1)
                        scroll_screen();
                    else
                        model_row++;
                end
            end
        endcase
        if (model_row >= ROWS)
            model_row = ROWS - 1;
    endfunction

    function automatic rsp_t console_step(input req_t item);
        rsp_t reply;
        int   cell_index;
        reply.cell_value = '0;
        case (item.command)
            CMD_WRITE: put_char(item.char_code);
            CMD_SET:
            begin
                model_col = int'(item.column_in) % COLUMNS;
                model_row = int'(item.row_in) % ROWS;
            end
            CMD_CLEAR: fill_screen({attr_model, SPACE_CHAR});
            default:
            begin
                cell_index = (int'(item.row_in) % ROWS) * COLUMNS
                           + (int'(item.column_in) % COLUMNS);
                reply.cell_value = screen_model[cell_index];
            end
        endcase
        reply.cursor_col = model_col[6:0];
        reply.cursor_row = model_row[4:0];
        return reply;
    endfunction

    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return 8'($urandom_range(32, 255));
        else if (roll < 85)
            return CH_CR;
        else if (roll < 90)
            return CH_LF;
        else if (roll < 95)
            return CH_TAB;
        else if (roll < 97)
            return CH_NUL;
        else if (roll < 98)
            return CH_FF;
        return 8'($urandom_range(0, 31));
    endfunction

    task automatic release_req();
        if (req_raised)
        begin
            req_if.valid <= 1'b0;
            req_raised = 1'b0;
        end
        burst_left = 0;
    endtask

    task automatic send_cmd(input logic [1:0] command, input logic [7:0] ch,
                            input logic [7:0] col, input logic [7:0] row);
        req_t item;
        item.command   = command;
        item.char_code = ch;
        item.column_in = col;
        item.row_in    = row;
        if (burst_left == 0)
        begin
            if (req_raised)
            begin
                req_if.valid <= 1'b0;
                req_raised = 1'b0;
            end
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(20, 60)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(100, 300);
            else
                burst_left = $urandom_range(1, 40);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        req_raised = 1'b1;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        console_replies.push_back(console_step(item));
        items_sent++;
        burst_left--;
    endtask

    task automatic set_attribute(input logic [7:0] value);
        release_req();
        while (console_replies.size() != 0)
            @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        attr_model = value;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_control_codes();
        send_cmd(CMD_WRITE, 8'h41, 8'd0, 8'd0);
        send_cmd(CMD_READ, 8'h00, 8'd0, 8'd0);
        send_cmd(CMD_WRITE, CH_NUL, 8'hFF, 8'hFF);
        send_cmd(CMD_WRITE, 8'hFF, 8'd0, 8'd0);
        send_cmd(CMD_WRITE, CH_CR, 8'd0, 8'd0);
        send_cmd(CMD_WRITE, CH_LF, 8'd0, 8'd0);
        send_cmd(CMD_WRITE, CH_TAB, 8'd0, 8'd0);
        send_cmd(CMD_SET, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_READ, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_SET, 8'h00, 8'd79, 8'd23);
        send_cmd(CMD_WRITE, 8'h5A, 8'd0, 8'd0);
        send_cmd(CMD_SET, 8'h00, 8'd79, 8'd24);
        send_cmd(CMD_WRITE, 8'h51, 8'd0, 8'd0);
        send_cmd(CMD_READ, 8'h00, 8'd79, 8'd23);
        send_cmd(CMD_WRITE, CH_LF, 8'd0, 8'd0);
        send_cmd(CMD_SET, 8'h00, 8'd76, 8'd24);
        send_cmd(CMD_WRITE, CH_TAB, 8'd0, 8'd0);
        send_cmd(CMD_READ, 8'h00, 8'd78, 8'd23);
        send_cmd(CMD_SET, 8'h00, 8'd76, 8'd10);
        send_cmd(CMD_WRITE, CH_TAB, 8'd0, 8'd0);
        send_cmd(CMD_WRITE, CH_FF, 8'd0, 8'd0);
        send_cmd(CMD_WRITE, 8'h42, 8'd0, 8'd0);
        send_cmd(CMD_CLEAR, 8'h00, 8'd0, 8'd0);
        send_cmd(CMD_READ, 8'h00, 8'd0, 8'd0);
        send_cmd(CMD_READ, 8'h00, 8'd0, 8'd24);
    endtask

    task automatic test_attribute_extremes();
        set_attribute(8'h00);
        send_cmd(CMD_SET, 8'h00, 8'd0, 8'd0);
        send_cmd(CMD_WRITE, 8'h61, 8'd0, 8'd0);
        send_cmd(CMD_WRITE, CH_TAB, 8'd0, 8'd0);
        send_cmd(CMD_READ, 8'h00, 8'd0, 8'd0);
        send_cmd(CMD_READ, 8'h00, 8'd3, 8'd0);
        set_attribute(8'hFF);
        send_cmd(CMD_WRITE, 8'h7E, 8'd0, 8'd0);
        send_cmd(CMD_WRITE, CH_TAB, 8'd0, 8'd0);
        send_cmd(CMD_READ, 8'h00, 8'd9, 8'd0);
        send_cmd(CMD_CLEAR, 8'h00, 8'd0, 8'd0);
        send_cmd(CMD_READ, 8'h00, 8'd40, 8'd12);
        send_cmd(CMD_SET, 8'h00, 8'd0, 8'd24);
        send_cmd(CMD_WRITE, CH_LF, 8'd0, 8'd0);
        send_cmd(CMD_READ, 8'h00, 8'd5, 8'd24);
        send_cmd(CMD_WRITE, CH_FF, 8'd0, 8'd0);
        send_cmd(CMD_READ, 8'h00, 8'd79, 8'd24);
    endtask

    task automatic test_random_screen();
        logic [7:0] attr_value;
        logic [7:0] run_col;
        logic [7:0] run_row;
        int         target;
        int         roll;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: attr_value = 8'h00;
                1: attr_value = 8'hFF;
                2: attr_value = ATTR_RESET;
                default: attr_value = 8'($urandom_range(0, 255));
            endcase
            set_attribute(attr_value);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                begin
                    run_row = ($urandom_range(0, 3) == 0) ? 8'(ROWS - 1)
                                                          : 8'($urandom_range(0, 255));
                    run_col = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(60, 79))
                                                          : 8'($urandom_range(0, 255));
                    send_cmd(CMD_SET, 8'($urandom_range(0, 255)), run_col, run_row);
                    repeat ($urandom_range(2, 24))
                        send_cmd(CMD_WRITE, pick_char(), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)));
                    repeat ($urandom_range(1, 4))
                        send_cmd(CMD_READ, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), run_row);
                end
                else if (roll < 75)
                begin
                    repeat ($urandom_range(1, 6))
                        send_cmd(CMD_READ, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
                else
                begin
                    roll = $urandom_range(0, 99);
                    send_cmd((roll < 2) ? CMD_CLEAR : (roll < 40) ? CMD_WRITE
                             : (roll < 70) ? CMD_SET : CMD_READ,
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial
    begin : result_checker
        rsp_t expected;
        rsp_t actual;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
            begin
                actual = rsp_if.data;
                if (console_replies.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected reply: cell %h col %0d row %0d",
                                 actual.cell_value, actual.cursor_col, actual.cursor_row);
                end
                else
                begin
                    expected = console_replies.pop_front();
                    if (actual.cell_value !== expected.cell_value
                        || actual.cursor_col !== expected.cursor_col
                        || actual.cursor_row !== expected.cursor_row)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected cell %h col %0d row %0d, got cell %h col %0d row %0d",
                                     expected.cell_value, expected.cursor_col,
                                     expected.cursor_row, actual.cell_value,
                                     actual.cursor_col, actual.cursor_row);
                    end
                end
            end
        end
    end

    initial
    begin : reply_stall
        int hold_left;
        int stall_mode;
        hold_left  = 0;
        stall_mode = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                hold_left  = $urandom_range(64, 512);
            end
            hold_left--;
            case (stall_mode)
                0: rsp_if.ready <= 1'b1;
                1: rsp_if.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if ($urandom_range(0, 15) == 0)
                        rsp_if.ready <= ~rsp_if.ready;
                end
            endcase
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        errors       = 0;
        items_sent   = 0;
        burst_left   = 0;
        req_raised   = 1'b0;
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        fill_screen(SCROLL_BLANK);
        model_col  = 0;
        model_row  = 0;
        attr_model = ATTR_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_control_codes();
        test_attribute_extremes();
        test_random_screen();

        // drain outstanding transactions, then allow for a late clear pass
        release_req();
        while (console_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && console_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
